// File: hw/rtl/isq_pkg.sv
// shared constants, payload types and codes of the input-queued switch scheduler
package isq_pkg;

    localparam int MAX_PORTS = 8;
    localparam int MAX_DEPTH = 8;
    localparam int TIME_BITS = 16;

    localparam int PORT_W = 3;
    localparam int PTR_W  = 3;
    localparam int FILL_W = 4;
    localparam int CFG_W  = 4;
    localparam int ADDR_W = PORT_W + PTR_W;
    localparam int MEM_DEPTH = MAX_PORTS * MAX_DEPTH;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] EV_ACCEPT = 2'd0;
    localparam logic [1:0] EV_DROP   = 2'd1;
    localparam logic [1:0] EV_REPORT = 2'd2;

    localparam logic CFG_PORT_COUNT   = 1'b0;
    localparam logic CFG_BUFFER_LIMIT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [PORT_W-1:0] in_port;
        logic [PORT_W-1:0] dest_port;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           event_res;
        logic [PORT_W-1:0]    port_index;
        logic                 granted;
        logic [PORT_W-1:0]    granted_output;
        logic [TIME_BITS-1:0] delay;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic [PORT_W-1:0]    dest;
        logic [TIME_BITS-1:0] slot;
    } t_entry;

endpackage

// File: hw/rtl/isq_queue_mem.sv
// packet storage of all input queues, one write and one registered read port
module isq_queue_mem (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [isq_pkg::ADDR_W-1:0] i_wr_addr,
    input  isq_pkg::t_entry       i_wr_data,
    input  logic                  i_rd_en,
    input  logic [isq_pkg::ADDR_W-1:0] i_rd_addr,
    output isq_pkg::t_entry       o_rd_data
);
    import isq_pkg::*;

    t_entry r_mem [MEM_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/input_queued_switch_hol_scheduler.sv
// top level: head-of-line fifo scheduler of an input-queued crossbar
//
// Each input port owns a fifo of packets kept in one shared queue memory
// (destination and arrival slot per entry). An arrival beat is accepted,
// then decided in S_ARR once the output register is free: it is queued
// with the current slot or dropped, and one result beat with last set follows.
// A tick beat clears the output claims and visits the active inputs from
// port 0 upward, one per cycle while the output is not stalled, giving one
// report beat each; the slot then advances. A tick is accepted, primes the
// registered read of the queue memory in S_RD, then reports the ports in S_EV,
// since the single memory read port fetches one head per cycle and a single
// delay subtractor serves every port in turn. A stalled output holds the
// sequence where it stands. The block takes no new beat until the current
// one has put its last result into the output register. Configuration
// beats are taken only while no input beat is in progress. No clearing pass
// is needed: only entries counted by the per-port fill counts are used.
module input_queued_switch_hol_scheduler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  isq_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output isq_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [isq_pkg::CFG_W-1:0] i_cfg_data
);
    import isq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARR,
        S_RD,
        S_EV
    } t_state;

    // control and queue bookkeeping
    t_state                r_state,       n_state;
    t_in_item              r_item,        n_item;
    logic [PORT_W-1:0]     r_port,        n_port;
    logic [MAX_PORTS-1:0]  r_claimed,     n_claimed;
    logic [TIME_BITS-1:0]  r_slot,        n_slot;
    logic [PTR_W-1:0]      r_head [MAX_PORTS];
    logic [PTR_W-1:0]      n_head [MAX_PORTS];
    logic [FILL_W-1:0]     r_fill [MAX_PORTS];
    logic [FILL_W-1:0]     n_fill [MAX_PORTS];
    logic [CFG_W-1:0]      r_port_count,  n_port_count;
    logic [CFG_W-1:0]      r_buf_limit,   n_buf_limit;
    logic                  r_out_valid,   n_out_valid;
    t_out_item             r_out,         n_out;

    // queue memory interface
    logic                  mem_wr_en;
    logic [ADDR_W-1:0]     mem_wr_addr;
    t_entry                mem_wr_data;
    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_rd_addr;
    t_entry                mem_rd_data;

    logic [FILL_W-1:0]     active;
    logic [FILL_W-1:0]     limit;
    logic                  out_free;
    logic [PORT_W-1:0]     next_port;
    logic                  is_last;
    logic [TIME_BITS-1:0]  delay_calc;
    logic                  drop;
    logic                  grant;

    isq_queue_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // port count zero acts as one, above the port limit it saturates
    assign active = (r_port_count == '0) ? FILL_W'(1) :
                    (r_port_count > FILL_W'(MAX_PORTS)) ? FILL_W'(MAX_PORTS) : r_port_count;
    assign limit  = (r_buf_limit > FILL_W'(MAX_DEPTH)) ? FILL_W'(MAX_DEPTH) : r_buf_limit;

    // output register frees up when empty or taken this cycle
    assign out_free  = !r_out_valid || !i_out_stall;
    assign next_port = PORT_W'(r_port + PORT_W'(1));
    assign is_last   = (FILL_W'(r_port) + FILL_W'(1)) == active;

    // shared delay unit: slot minus arrival plus one, wraps with the slot
    assign delay_calc = r_slot - mem_rd_data.slot + TIME_BITS'(1);

    // arrival decision: inactive ports or a full fifo drop the packet
    assign drop = ({1'b0, r_item.in_port} >= active) ||
                  ({1'b0, r_item.dest_port} >= active) ||
                  (r_fill[r_item.in_port] >= limit);

    // head grant: queue not empty and its output still free in this slot
    assign grant = (r_fill[r_port] != '0) && !r_claimed[mem_rd_data.dest];

    assign mem_wr_data.dest = r_item.dest_port;
    assign mem_wr_data.slot = r_slot;
    assign mem_wr_addr = {r_item.in_port,
                          PTR_W'(r_head[r_item.in_port] + r_fill[r_item.in_port][PTR_W-1:0])};

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_port       = r_port;
        n_claimed    = r_claimed;
        n_slot       = r_slot;
        n_head       = r_head;
        n_fill       = r_fill;
        n_port_count = r_port_count;
        n_buf_limit  = r_buf_limit;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = {r_port, r_head[r_port]};

        // configuration beats, only written while idle
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PORT_COUNT:   n_port_count = i_cfg_data;
                CFG_BUFFER_LIMIT: n_buf_limit  = i_cfg_data;
                default:          n_port_count = r_port_count;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (i_in_data.operation == OP_TICK) begin
                        n_claimed = '0;
                        n_port    = '0;
                        n_state   = S_RD;
                    end else begin
                        n_state = S_ARR;
                    end
                end
            end
            S_ARR: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.event_res      = drop ? EV_DROP : EV_ACCEPT;
                    n_out.port_index     = r_item.in_port;
                    n_out.granted        = 1'b0;
                    n_out.granted_output = '0;
                    n_out.delay          = '0;
                    n_out.last           = 1'b1;
                    if (!drop) begin
                        mem_wr_en = 1'b1;
                        n_fill[r_item.in_port] = FILL_W'(r_fill[r_item.in_port] + FILL_W'(1));
                    end
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                // prime the head read of the first port
                mem_rd_en = 1'b1;
                n_state   = S_EV;
            end
            S_EV: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.event_res      = EV_REPORT;
                    n_out.port_index     = r_port;
                    n_out.granted        = grant;
                    n_out.granted_output = grant ? mem_rd_data.dest : '0;
                    n_out.delay          = grant ? delay_calc : '0;
                    n_out.last           = is_last;
                    if (grant) begin
                        n_claimed[mem_rd_data.dest] = 1'b1;
                        n_head[r_port] = PTR_W'(r_head[r_port] + PTR_W'(1));
                        n_fill[r_port] = FILL_W'(r_fill[r_port] - FILL_W'(1));
                    end
                    if (is_last) begin
                        n_slot  = r_slot + TIME_BITS'(1);
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next head; its pointer is not touched here
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = {next_port, r_head[next_port]};
                        n_port      = next_port;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_port       <= '0;
            r_claimed    <= '0;
            r_slot       <= '0;
            r_port_count <= CFG_W'(8);
            r_buf_limit  <= CFG_W'(4);
            r_out_valid  <= 1'b0;
            for (int p = 0; p < MAX_PORTS; p++) begin
                r_head[p] <= '0;
                r_fill[p] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_port       <= n_port;
            r_claimed    <= n_claimed;
            r_slot       <= n_slot;
            r_port_count <= n_port_count;
            r_buf_limit  <= n_buf_limit;
            r_out_valid  <= n_out_valid;
            r_head       <= n_head;
            r_fill       <= n_fill;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = (r_state == S_IDLE);

endmodule

// File: hw/rtl/isq_checker.sv
// port-level checks of the scheduler, bound to the top level
module isq_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  isq_pkg::t_in_item    i_in_data,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  isq_pkg::t_out_item   o_out_data
);
    import isq_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // an accepted beat keeps the input closed in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a beat");

    // arrival results are single and carry no grant
    a_arrival_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_res != EV_REPORT)
            |-> o_out_data.last && !o_out_data.granted && (o_out_data.delay == '0))
        else $error("arrival result malformed");

    // a report without a grant names no output and no delay
    a_idle_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_res == EV_REPORT) && !o_out_data.granted
            |-> (o_out_data.granted_output == '0) && (o_out_data.delay == '0))
        else $error("report without grant carries data");

endmodule

bind input_queued_switch_hol_scheduler isq_checker u_isq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: tb/input_queued_switch_hol_scheduler_test.sv
// self-checking testbench of the input-queued switch head-of-line scheduler
module input_queued_switch_hol_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import isq_pkg::*;

    // settling margin covering the longest tick and the output register
    localparam int SETTLE_CYCLES = 14;
    localparam int IDLE_PCT = 36;
    localparam int SHOWN_MISMATCHES = 10;

    // dut ports
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    input_queued_switch_hol_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scheduler state as the testbench tracks it
    // ------------------------------------------------------------------
    logic [PORT_W-1:0]    queued_dest [MAX_PORTS][MAX_DEPTH];
    logic [TIME_BITS-1:0] queued_slot [MAX_PORTS][MAX_DEPTH];
    logic [PTR_W-1:0]     queue_head  [MAX_PORTS];
    logic [FILL_W-1:0]    queue_fill  [MAX_PORTS];
    logic [TIME_BITS-1:0] slot_now;
    logic [MAX_PORTS-1:0] claimed_outputs;
    logic [CFG_W-1:0]     cfg_ports;
    logic [CFG_W-1:0]     cfg_limit;

    // result beats still owed by the dut, oldest first
    t_out_item owed_results[$];

    // no idling on either side while set
    logic quiet = 1'b0;

    int mismatch_count = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int accepts_seen = 0;
    int drops_seen = 0;
    int grants_seen = 0;
    int ticks_sent = 0;

    // port_count clamped into 1..MAX_PORTS
    function automatic int live_ports();
        if (cfg_ports == 0) return 1;
        if (cfg_ports > MAX_PORTS) return MAX_PORTS;
        return int'(cfg_ports);
    endfunction

    // append one result beat to the owed list
    function automatic void owe_result(input t_out_item r);
        owed_results = {owed_results, r};
    endfunction

    // work out the result beats of one accepted input beat and advance the state
    task automatic schedule_beat(input t_in_item beat);
        int n;
        int lim;
        int i;
        logic [PTR_W-1:0]  pos;
        logic [PORT_W-1:0] d;
        t_out_item r;
        n = live_ports();
        lim = (cfg_limit > MAX_DEPTH) ? MAX_DEPTH : int'(cfg_limit);
        if (beat.operation == OP_ARRIVAL) begin
            r = '0;
            r.port_index = beat.in_port;
            r.last = 1'b1;
            if (beat.in_port >= n || beat.dest_port >= n
                    || queue_fill[beat.in_port] >= lim) begin
                r.event_res = EV_DROP;
            end else begin
                // fifo slot wraps modulo the depth through the pointer width
                pos = queue_head[beat.in_port] + queue_fill[beat.in_port][PTR_W-1:0];
                queued_dest[beat.in_port][pos] = beat.dest_port;
                queued_slot[beat.in_port][pos] = slot_now;
                queue_fill[beat.in_port] = queue_fill[beat.in_port] + 1'b1;
                r.event_res = EV_ACCEPT;
            end
            owe_result(r);
        end else begin
            claimed_outputs = '0;
            for (i = 0; i < n; i++) begin
                r = '0;
                r.event_res = EV_REPORT;
                r.port_index = i[PORT_W-1:0];
                r.last = (i == n - 1);
                if (queue_fill[i] != 0) begin
                    d = queued_dest[i][queue_head[i]];
                    // head-of-line blocking: a claimed output stalls the whole fifo
                    if (!claimed_outputs[d]) begin
                        claimed_outputs[d] = 1'b1;
                        r.granted = 1'b1;
                        r.granted_output = d;
                        r.delay = slot_now - queued_slot[i][queue_head[i]] + 1'b1;
                        queue_head[i] = queue_head[i] + 1'b1;
                        queue_fill[i] = queue_fill[i] - 1'b1;
                    end
                end
                owe_result(r);
            end
            slot_now = slot_now + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // output side: random stall and the result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (owed_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES)
                $display("unexpected result: ev %0d port %0d gr %0d out %0d dly %0d last %0d",
                         got.event_res, got.port_index, got.granted,
                         got.granted_output, got.delay, got.last);
            return;
        end
        want = owed_results.pop_front();
        if (got.event_res !== want.event_res || got.port_index !== want.port_index
                || got.granted !== want.granted || got.granted_output !== want.granted_output
                || got.delay !== want.delay || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES) begin
                $display("mismatch: expected ev %0d port %0d gr %0d out %0d dly %0d last %0d",
                         want.event_res, want.port_index, want.granted,
                         want.granted_output, want.delay, want.last);
                $display("          got      ev %0d port %0d gr %0d out %0d dly %0d last %0d",
                         got.event_res, got.port_index, got.granted,
                         got.granted_output, got.delay, got.last);
            end
        end
        if (got.event_res == EV_ACCEPT) accepts_seen++;
        if (got.event_res == EV_DROP) drops_seen++;
        if (got.event_res == EV_REPORT && got.granted) grants_seen++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result(o_out_data);
    end

    // ------------------------------------------------------------------
    // input and configuration side
    // ------------------------------------------------------------------
    function automatic t_in_item make_beat(input logic op, input int ip, input int dp);
        t_in_item b;
        b.operation = op;
        b.in_port = ip[PORT_W-1:0];
        b.dest_port = dp[PORT_W-1:0];
        return b;
    endfunction

    // random gap before a beat, payload wanders while valid is low
    task automatic idle_gap();
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            i_in_data <= t_in_item'($urandom);
            @(posedge i_clk);
        end
    endtask

    // offer one beat and hold it until accepted, then predict its results
    task automatic send_beat(input t_in_item beat, input bit typed, input t_out_item want);
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
        if (beat.operation == OP_TICK) ticks_sent++;
        schedule_beat(beat);
        // an arrival with a hand-written result replaces the predicted one
        if (typed) begin
            owed_results[owed_results.size() - 1] = want;
        end
    endtask

    // wait until every owed beat has arrived and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (sel == CFG_PORT_COUNT) cfg_ports = val;
        else cfg_limit = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct {
        bit               is_cfg;
        logic             reg_sel;
        logic [CFG_W-1:0] reg_val;
        t_in_item         beat;
        bit               typed;
        t_out_item        want;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic void plan_arrival(input int ip, input int dp, input logic [1:0] ev);
        t_plan_row row;
        row = '{default: '0};
        row.beat = make_beat(OP_ARRIVAL, ip, dp);
        row.typed = 1'b1;
        row.want = '0;
        row.want.event_res = ev;
        row.want.port_index = ip[PORT_W-1:0];
        row.want.last = 1'b1;
        plan = {plan, row};
    endfunction

    function automatic void plan_tick();
        t_plan_row row;
        row = '{default: '0};
        row.beat = make_beat(OP_TICK, 0, 0);
        plan = {plan, row};
    endfunction

    function automatic void plan_write(input logic sel, input int val);
        t_plan_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.reg_sel = sel;
        row.reg_val = val[CFG_W-1:0];
        plan = {plan, row};
    endfunction

    // phase settings of the random part: fixed ones first, starting with the extremes, then two random ones
    int phase_ports[8] = '{8, 1, 3, 8, 6, 2, 0, 0};
    int phase_limit[8] = '{8, 1, 2, 1, 5, 8, 0, 0};

    function automatic t_in_item random_beat();
        t_in_item b;
        int n;
        n = live_ports();
        b = t_in_item'($urandom);
        b.operation = ($urandom_range(99) < 28) ? OP_TICK : OP_ARRIVAL;
        // mostly legal ports, some aimed at outputs 0 and 1 to provoke blocking,
        // the rest left raw so that inactive ports get hit
        if ($urandom_range(99) < 85) begin
            b.in_port = PORT_W'($urandom_range(n - 1));
            if ($urandom_range(99) < 30)
                b.dest_port = PORT_W'($urandom_range((n > 1) ? 1 : 0));
            else
                b.dest_port = PORT_W'($urandom_range(n - 1));
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int k;
        int p;
        int j;
        t_out_item none;

        none = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_PORT_COUNT;
        i_cfg_data <= '0;

        for (k = 0; k < MAX_PORTS; k++) begin
            queue_head[k] = '0;
            queue_fill[k] = '0;
            for (j = 0; j < MAX_DEPTH; j++) begin
                queued_dest[k][j] = '0;
                queued_slot[k][j] = '0;
            end
        end
        slot_now = '0;
        claimed_outputs = '0;
        cfg_ports = 4'd8;
        cfg_limit = 4'd4;

        // tick on empty fifos, then head-of-line conflict on output 0
        plan_tick();
        plan_arrival(7, 7, EV_ACCEPT);
        plan_arrival(0, 0, EV_ACCEPT);
        plan_arrival(1, 0, EV_ACCEPT);
        plan_tick();
        plan_tick();
        // fill one fifo to the reset limit, the next arrival drops
        plan_arrival(2, 3, EV_ACCEPT);
        plan_arrival(2, 3, EV_ACCEPT);
        plan_arrival(2, 3, EV_ACCEPT);
        plan_arrival(2, 3, EV_ACCEPT);
        plan_arrival(2, 3, EV_DROP);
        // inactive input and inactive output
        plan_write(CFG_PORT_COUNT, 3);
        plan_arrival(3, 0, EV_DROP);
        plan_arrival(0, 5, EV_DROP);
        plan_tick();
        // zero limit drops everything
        plan_write(CFG_BUFFER_LIMIT, 0);
        plan_arrival(0, 0, EV_DROP);
        // limit lowered under the fill: drops but keeps its packets
        plan_write(CFG_BUFFER_LIMIT, 2);
        plan_arrival(2, 1, EV_DROP);
        plan_tick();
        // zero port count acts as one port
        plan_write(CFG_PORT_COUNT, 0);
        plan_tick();
        plan_arrival(1, 0, EV_DROP);
        // oversized registers clamp to the maximum
        plan_write(CFG_PORT_COUNT, 15);
        plan_write(CFG_BUFFER_LIMIT, 15);
        plan_arrival(0, 6, EV_ACCEPT);
        plan_arrival(5, 6, EV_ACCEPT);
        // output 6 turns inactive but its queued packet is still served
        plan_write(CFG_PORT_COUNT, 6);
        plan_tick();
        plan_write(CFG_PORT_COUNT, 8);
        plan_arrival(7, 0, EV_ACCEPT);
        plan_tick();

        phase_ports[6] = $urandom_range(1, MAX_PORTS);
        phase_limit[6] = $urandom_range(0, 15);
        phase_ports[7] = $urandom_range(0, 15);
        phase_limit[7] = $urandom_range(1, MAX_DEPTH);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                settle();
                write_reg(plan[k].reg_sel, plan[k].reg_val);
            end else begin
                idle_gap();
                send_beat(plan[k].beat, plan[k].typed, plan[k].want);
            end
        end

        // random phases, each under its own register setting
        for (p = 0; p < 8; p++) begin
            settle();
            write_reg(CFG_PORT_COUNT, phase_ports[p][CFG_W-1:0]);
            write_reg(CFG_BUFFER_LIMIT, phase_limit[p][CFG_W-1:0]);
            // phases 3 and 4 run with no idling on either side
            quiet <= (p == 3 || p == 4);
            for (j = 0; j < 48; j++) begin
                idle_gap();
                send_beat(random_beat(), 1'b0, none);
            end
        end

        // a packet parks on port 1 while only port 0 is active, then is
        // served once port 1 comes back
        settle();
        quiet <= 1'b0;
        write_reg(CFG_PORT_COUNT, 4'd2);
        write_reg(CFG_BUFFER_LIMIT, 4'd8);
        send_beat(make_beat(OP_ARRIVAL, 1, 1), 1'b0, none);
        settle();
        write_reg(CFG_PORT_COUNT, 4'd1);
        repeat (4) send_beat(make_beat(OP_TICK, 0, 0), 1'b0, none);
        settle();
        write_reg(CFG_PORT_COUNT, 4'd2);
        idle_gap();
        send_beat(make_beat(OP_TICK, 0, 0), 1'b0, none);

        settle();
        $display("ran %0d input beats (%0d ticks), checked %0d result beats",
                 beats_sent, ticks_sent, results_seen);
        $display("%0d arrivals queued, %0d dropped, %0d grants",
                 accepts_seen, drops_seen, grants_seen);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("input_queued_switch_hol_scheduler_test OK");
        end else begin
            $display("input_queued_switch_hol_scheduler_test NOT OK");
        end
        $finish;
    end

    // hang guard, well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("input_queued_switch_hol_scheduler_test NOT OK");
        $finish;
    end

endmodule
